// ----- rtl/tefx_pkg.sv -----
// ============================================================================
// tefx_pkg
// Shared types, constants and item tables of the tetrahedron edge and face
// extractor.
// ============================================================================
package tefx_pkg;

    localparam int VW          = 31;
    localparam int NUM_PAIRS   = 6;
    localparam int NUM_ITEMS   = 10;
    localparam int STEP_W      = $clog2(NUM_ITEMS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_ITEMS - 1);

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_FACE = 1'b1;

    localparam logic [2:0] PERM_NONE = 3'd0;
    localparam logic [2:0] PERM_ABC  = 3'd1;
    localparam logic [2:0] PERM_CAB  = 3'd2;
    localparam logic [2:0] PERM_BCA  = 3'd3;
    localparam logic [2:0] PERM_CBA  = 3'd4;
    localparam logic [2:0] PERM_BAC  = 3'd5;
    localparam logic [2:0] PERM_ACB  = 3'd6;

    typedef logic [VW-1:0] vtx_t;
    typedef logic [1:0]    vidx_t;
    typedef logic [2:0]    pidx_t;

    // One queued tetrahedron with its pairwise comparison results.
    typedef struct packed {
        vtx_t [3:0]           v;
        vtx_t                 cell_idx;
        logic [NUM_PAIRS-1:0] lt;
        logic [NUM_PAIRS-1:0] eq;
    } tet_t;

    // What one output step of a tetrahedron emits.
    typedef struct packed {
        logic       kind;
        vidx_t      a;
        vidx_t      b;
        vidx_t      c;
        logic [2:0] num;
    } step_t;

    typedef struct packed {
        logic              kind;
        vtx_t              low_vertex;
        vtx_t              mid_vertex;
        vtx_t              high_vertex;
        vtx_t              owner_cell;
        logic signed [3:0] local_number;
        logic [2:0]        perm_code;
        logic              degenerate;
        logic              last;
    } item_t;

    function automatic vidx_t pair_first(input pidx_t p);
        vidx_t r;
        unique case (p)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic vidx_t pair_second(input pidx_t p);
        vidx_t r;
        unique case (p)
            3'd0:       r = 2'd1;
            3'd1, 3'd3: r = 2'd2;
            default:    r = 2'd3;
        endcase
        return r;
    endfunction

    // Comparison slot of an unordered vertex pair; i and j must differ.
    function automatic pidx_t pair_idx(input vidx_t i, input vidx_t j);
        vidx_t lo;
        vidx_t hi;
        pidx_t r;
        lo = (i < j) ? i : j;
        hi = (i < j) ? j : i;
        unique case ({lo, hi})
            {2'd0, 2'd1}: r = 3'd0;
            {2'd0, 2'd2}: r = 3'd1;
            {2'd0, 2'd3}: r = 3'd2;
            {2'd1, 2'd2}: r = 3'd3;
            {2'd1, 2'd3}: r = 3'd4;
            default:      r = 3'd5;
        endcase
        return r;
    endfunction

    function automatic step_t step_info(input logic [STEP_W-1:0] s);
        step_t r;
        unique case (s)
            4'd0:    r = '{KIND_EDGE, 2'd0, 2'd1, 2'd0, 3'd1};
            4'd1:    r = '{KIND_EDGE, 2'd0, 2'd2, 2'd0, 3'd2};
            4'd2:    r = '{KIND_EDGE, 2'd0, 2'd3, 2'd0, 3'd3};
            4'd3:    r = '{KIND_EDGE, 2'd1, 2'd2, 2'd0, 3'd4};
            4'd4:    r = '{KIND_EDGE, 2'd2, 2'd3, 2'd0, 3'd5};
            4'd5:    r = '{KIND_EDGE, 2'd3, 2'd1, 2'd0, 3'd6};
            4'd6:    r = '{KIND_FACE, 2'd1, 2'd2, 2'd3, 3'd1};
            4'd7:    r = '{KIND_FACE, 2'd0, 2'd3, 2'd2, 3'd2};
            4'd8:    r = '{KIND_FACE, 2'd0, 2'd1, 2'd3, 3'd3};
            default: r = '{KIND_FACE, 2'd0, 2'd2, 2'd1, 3'd4};
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/tefx_ifs.sv -----
// ============================================================================
// tefx channel interfaces
// Valid/ready channels for input tetrahedra and for edge and face items.
// ============================================================================
interface tefx_tet_if;
    logic                valid;
    logic                ready;
    tefx_pkg::vtx_t      vertex_one;
    tefx_pkg::vtx_t      vertex_two;
    tefx_pkg::vtx_t      vertex_three;
    tefx_pkg::vtx_t      vertex_four;
    tefx_pkg::vtx_t      cell_number;

    modport source (
        output valid, vertex_one, vertex_two, vertex_three, vertex_four, cell_number,
        input  ready
    );
    modport sink (
        input  valid, vertex_one, vertex_two, vertex_three, vertex_four, cell_number,
        output ready
    );
endinterface

interface tefx_item_if;
    logic              valid;
    logic              ready;
    logic              kind;
    tefx_pkg::vtx_t    low_vertex;
    tefx_pkg::vtx_t    mid_vertex;
    tefx_pkg::vtx_t    high_vertex;
    tefx_pkg::vtx_t    owner_cell;
    logic signed [3:0] local_number;
    logic [2:0]        perm_code;
    logic              degenerate;
    logic              last;

    modport source (
        output valid, kind, low_vertex, mid_vertex, high_vertex, owner_cell,
               local_number, perm_code, degenerate, last,
        input  ready
    );
    modport sink (
        input  valid, kind, low_vertex, mid_vertex, high_vertex, owner_cell,
               local_number, perm_code, degenerate, last,
        output ready
    );
endinterface

// ----- rtl/tefx_front.sv -----
// ============================================================================
// tefx_front
// Accepts tetrahedra and classifies every vertex pair as less or equal.
// ============================================================================
module tefx_front (
    tefx_tet_if.sink         tet,
    output tefx_pkg::tet_t   push_data,
    output logic             push_valid,
    input  logic             push_ready
);

    tefx_pkg::vtx_t [3:0] v;

    assign v          = {tet.vertex_four, tet.vertex_three, tet.vertex_two, tet.vertex_one};
    assign tet.ready  = push_ready;
    assign push_valid = tet.valid;

    always_comb
    begin
        push_data.v        = v;
        push_data.cell_idx = tet.cell_number;
        for (int p = 0; p < tefx_pkg::NUM_PAIRS; p++)
        begin
            push_data.lt[p] = v[tefx_pkg::pair_first(3'(p))] < v[tefx_pkg::pair_second(3'(p))];
            push_data.eq[p] = v[tefx_pkg::pair_first(3'(p))] == v[tefx_pkg::pair_second(3'(p))];
        end
    end

endmodule

// ----- rtl/tefx_queue.sv -----
// ============================================================================
// tefx_queue
// Short FIFO of classified tetrahedra between the front and the back.
// ============================================================================
module tefx_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  tefx_pkg::tet_t   push_data,
    output logic             push_ready,
    input  logic             pop,
    output tefx_pkg::tet_t   head,
    output logic             head_valid
);

    tefx_pkg::tet_t                entry_reg [tefx_pkg::QUEUE_DEPTH];
    logic [tefx_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tefx_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tefx_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    localparam logic [tefx_pkg::QPTR_W-1:0] PTR_LAST =
        tefx_pkg::QPTR_W'(tefx_pkg::QUEUE_DEPTH - 1);
    localparam logic [tefx_pkg::QCNT_W-1:0] CNT_FULL =
        tefx_pkg::QCNT_W'(tefx_pkg::QUEUE_DEPTH);

    assign push_ready = count_reg != CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/tefx_back.sv -----
// ============================================================================
// tefx_back
// Steps through the edges and faces of the head tetrahedron and
// presents one sorted item per cycle, unless stalled, from an output register.
// ============================================================================
module tefx_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tefx_pkg::tet_t   head,
    input  logic             head_valid,
    output logic             pop,
    tefx_item_if.source      item
);

    logic [tefx_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        valid_reg, valid_next;
    tefx_pkg::item_t             item_reg, item_next;
    tefx_pkg::step_t             si;
    logic                        load;
    tefx_pkg::vidx_t             sel_lo, sel_mid, sel_hi;
    logic                        swap;
    logic                        ab, bc, ac;
    logic                        eab, ebc, eac;
    logic                        deg;
    logic [2:0]                  perm;
    logic signed [3:0]           num_s;

    function automatic logic less(input tefx_pkg::tet_t t, input tefx_pkg::vidx_t i,
                                  input tefx_pkg::vidx_t j);
        tefx_pkg::pidx_t p;
        logic r;
        p = tefx_pkg::pair_idx(i, j);
        if (i < j)
        begin
            r = t.lt[p];
        end
        else
        begin
            r = !t.lt[p] && !t.eq[p];
        end
        return r;
    endfunction

    function automatic logic same(input tefx_pkg::tet_t t, input tefx_pkg::vidx_t i,
                                  input tefx_pkg::vidx_t j);
        return t.eq[tefx_pkg::pair_idx(i, j)];
    endfunction

    assign si    = tefx_pkg::step_info(step_reg);
    assign load  = head_valid && (!valid_reg || item.ready);
    assign pop   = load && (step_reg == tefx_pkg::LAST_STEP);
    assign num_s = $signed({1'b0, si.num});

    always_comb
    begin
        swap = less(head, si.b, si.a);
        ab   = less(head, si.a, si.b);
        bc   = less(head, si.b, si.c);
        ac   = less(head, si.a, si.c);
        eab  = same(head, si.a, si.b);
        ebc  = same(head, si.b, si.c);
        eac  = same(head, si.a, si.c);
        perm = tefx_pkg::PERM_NONE;
        deg  = 1'b0;
        sel_lo  = si.a;
        sel_mid = si.b;
        sel_hi  = si.c;
        if (si.kind == tefx_pkg::KIND_EDGE)
        begin
            deg     = eab;
            sel_lo  = swap ? si.b : si.a;
            sel_mid = swap ? si.a : si.b;
        end
        else
        begin
            deg = eab || ebc || eac;
            // With a tie only the sorted values matter, so each tie picks an order directly.
            priority if (eab)
            begin
                if (less(head, si.c, si.a))
                begin
                    sel_lo = si.c; sel_mid = si.a; sel_hi = si.b;
                end
            end
            else if (ebc)
            begin
                if (!ab)
                begin
                    sel_lo = si.b; sel_mid = si.c; sel_hi = si.a;
                end
            end
            else if (eac)
            begin
                if (!ab)
                begin
                    sel_lo = si.b; sel_mid = si.a; sel_hi = si.c;
                end
                else
                begin
                    sel_lo = si.a; sel_mid = si.c; sel_hi = si.b;
                end
            end
            else if (ab)
            begin
                if (bc)
                begin
                    perm = tefx_pkg::PERM_ABC;
                end
                else if (!ac)
                begin
                    sel_lo = si.c; sel_mid = si.a; sel_hi = si.b;
                    perm   = tefx_pkg::PERM_CAB;
                end
                else
                begin
                    sel_lo = si.a; sel_mid = si.c; sel_hi = si.b;
                    perm   = tefx_pkg::PERM_ACB;
                end
            end
            else
            begin
                if (!bc)
                begin
                    sel_lo = si.c; sel_mid = si.b; sel_hi = si.a;
                    perm   = tefx_pkg::PERM_CBA;
                end
                else if (!ac)
                begin
                    sel_lo = si.b; sel_mid = si.c; sel_hi = si.a;
                    perm   = tefx_pkg::PERM_BCA;
                end
                else
                begin
                    sel_lo = si.b; sel_mid = si.a; sel_hi = si.c;
                    perm   = tefx_pkg::PERM_BAC;
                end
            end
        end
    end

    always_comb
    begin
        item_next.kind        = si.kind;
        item_next.low_vertex  = head.v[sel_lo];
        item_next.mid_vertex  = head.v[sel_mid];
        item_next.high_vertex = (si.kind == tefx_pkg::KIND_EDGE) ? '0 : head.v[sel_hi];
        item_next.owner_cell  = head.cell_idx;
        item_next.local_number = (si.kind == tefx_pkg::KIND_EDGE && swap) ? -num_s : num_s;
        item_next.perm_code   = perm;
        item_next.degenerate  = deg;
        item_next.last        = step_reg == tefx_pkg::LAST_STEP;

        valid_next = valid_reg;
        step_next  = step_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = (step_reg == tefx_pkg::LAST_STEP) ? '0 : step_reg + 1'b1;
        end
        else if (item.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item.valid        = valid_reg;
    assign item.kind         = item_reg.kind;
    assign item.low_vertex   = item_reg.low_vertex;
    assign item.mid_vertex   = item_reg.mid_vertex;
    assign item.high_vertex  = item_reg.high_vertex;
    assign item.owner_cell   = item_reg.owner_cell;
    assign item.local_number = item_reg.local_number;
    assign item.perm_code    = item_reg.perm_code;
    assign item.degenerate   = item_reg.degenerate;
    assign item.last         = item_reg.last;

endmodule

// ----- rtl/tet_edge_face_extractor_unit.sv -----
// ============================================================================
// tet_edge_face_extractor_unit
// Splits each tetrahedron into its six sorted edges and four sorted faces.
// ============================================================================
// Usage:
// The tet channel takes one tetrahedron per transaction: four vertex indices
// and the cell index. The item channel returns one transaction for each edge
// and each face of it, the edges first and then the faces; last marks the final face.
// The front compares all six vertex pairs as the tetrahedron is accepted and
// writes the result into a two-entry queue. The back walks the head entry
// one item per cycle unless stalled and holds each item in an output register.
// With the block idle, an accepted tetrahedron is written into the queue
// and its first item is then loaded into the single item output register of the back.
// When the item receiver stalls, the current item holds and the back stops
// stepping; the tet channel keeps accepting until the queue is full.
// Reset empties the queue, clears the output valid and restarts the item
// counter; nothing else needs clearing.
module tet_edge_face_extractor_unit (
    input  logic         clk,
    input  logic         rst_n,
    tefx_tet_if.sink     tet,
    tefx_item_if.source  item
);

    tefx_pkg::tet_t push_data;
    logic           push_valid;
    logic           push_ready;
    tefx_pkg::tet_t head;
    logic           head_valid;
    logic           pop;

    tefx_front u_front (
        .tet        (tet),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    tefx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    tefx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .item       (item)
    );

endmodule

// ----- rtl/tefx_checker.sv -----
// ============================================================================
// tefx_checker
// Port-level checks on the item channel of the extractor.
// ============================================================================
module tefx_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              kind,
    input tefx_pkg::vtx_t    low_vertex,
    input tefx_pkg::vtx_t    mid_vertex,
    input tefx_pkg::vtx_t    high_vertex,
    input logic [2:0]        perm_code,
    input logic              degenerate
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(low_vertex))
        else $error("item dropped or changed while stalled");

    a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && kind == tefx_pkg::KIND_EDGE |->
            high_vertex == '0 && perm_code == tefx_pkg::PERM_NONE)
        else $error("edge item carries face fields");

    a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && kind == tefx_pkg::KIND_EDGE |->
            (degenerate ? (low_vertex == mid_vertex) : (low_vertex < mid_vertex)))
        else $error("edge item not sorted or flag wrong");

    a_face_order: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && kind == tefx_pkg::KIND_FACE && !degenerate |->
            low_vertex < mid_vertex && mid_vertex < high_vertex &&
            perm_code != tefx_pkg::PERM_NONE)
        else $error("face item not sorted or missing permutation code");

endmodule

bind tet_edge_face_extractor_unit tefx_checker u_tefx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .kind        (item.kind),
    .low_vertex  (item.low_vertex),
    .mid_vertex  (item.mid_vertex),
    .high_vertex (item.high_vertex),
    .perm_code   (item.perm_code),
    .degenerate  (item.degenerate)
);

// ----- dv/tet_edge_face_extractor_unit_test.sv -----
// ----------------------------------------------------------------------------
// tet_edge_face_extractor_unit_test
// Drives tetrahedra into the extractor in random bursts and checks every
// edge and face transaction field by field. Expected items come from an
// independent predictor of the edge and face split, and the item receiver
// stalls at random, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tet_edge_face_extractor_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int             RESET_CYCLES = 10;
    localparam int             RANDOM_TETS  = 420;
    localparam int             HOLD_CYCLES  = 160;
    localparam int             DRAIN_LIMIT  = 5000;
    localparam int             TAIL_CYCLES  = 20;
    localparam int             MAX_REPORTS  = 40;
    localparam tefx_pkg::vtx_t VMAX         = '1;

    // Vertex slots of the edges and faces, in emission order.
    localparam int EDGE_FROM [6] = '{0, 0, 0, 1, 2, 3};
    localparam int EDGE_TO   [6] = '{1, 2, 3, 2, 3, 1};
    localparam int FACE_A    [4] = '{1, 0, 0, 0};
    localparam int FACE_B    [4] = '{2, 3, 1, 2};
    localparam int FACE_C    [4] = '{3, 2, 3, 1};

    typedef struct packed {
        tefx_pkg::vtx_t [3:0] v;
        tefx_pkg::vtx_t       cell_idx;
    } tet_in_t;

    class edge_face_scoreboard;
        tefx_pkg::item_t upcoming_items[$];
        int unsigned     failures;
        int unsigned     reported;

        function int pending();
            return upcoming_items.size();
        endfunction

        function void add_expected(tefx_pkg::item_t it);
            upcoming_items.insert(upcoming_items.size(), it);
        endfunction

        // Expands one accepted tetrahedron into its edge and face items.
        function void note_tet(tet_in_t t);
            tefx_pkg::item_t   it;
            tefx_pkg::vtx_t    a;
            tefx_pkg::vtx_t    b;
            tefx_pkg::vtx_t    c;
            tefx_pkg::vtx_t    x;
            logic signed [3:0] num;
            for (int e = 0; e < 6; e++)
            begin
                a = t.v[EDGE_FROM[e]];
                b = t.v[EDGE_TO[e]];
                num = 4'(e + 1);
                it = '0;
                it.kind = tefx_pkg::KIND_EDGE;
                it.owner_cell = t.cell_idx;
                it.perm_code = tefx_pkg::PERM_NONE;
                if (a > b)
                begin
                    it.low_vertex = b;
                    it.mid_vertex = a;
                    it.local_number = -num;
                end
                else
                begin
                    it.low_vertex = a;
                    it.mid_vertex = b;
                    it.local_number = num;
                    it.degenerate = (a == b);
                end
                add_expected(it);
            end
            for (int f = 0; f < 4; f++)
            begin
                a = t.v[FACE_A[f]];
                b = t.v[FACE_B[f]];
                c = t.v[FACE_C[f]];
                it = '0;
                it.kind = tefx_pkg::KIND_FACE;
                it.owner_cell = t.cell_idx;
                it.local_number = 4'(f + 1);
                it.last = (f == 3);
                it.degenerate = (a == b) || (b == c) || (a == c);
                if (it.degenerate)
                begin
                    // Plain three-element sort; ties are allowed here.
                    if (a > b) begin x = a; a = b; b = x; end
                    if (b > c) begin x = b; b = c; c = x; end
                    if (a > b) begin x = a; a = b; b = x; end
                    it.low_vertex = a;
                    it.mid_vertex = b;
                    it.high_vertex = c;
                    it.perm_code = tefx_pkg::PERM_NONE;
                end
                else if (a < b)
                begin
                    if (b < c)
                    begin
                        it.low_vertex = a; it.mid_vertex = b; it.high_vertex = c;
                        it.perm_code = tefx_pkg::PERM_ABC;
                    end
                    else if (c < a)
                    begin
                        it.low_vertex = c; it.mid_vertex = a; it.high_vertex = b;
                        it.perm_code = tefx_pkg::PERM_CAB;
                    end
                    else
                    begin
                        it.low_vertex = a; it.mid_vertex = c; it.high_vertex = b;
                        it.perm_code = tefx_pkg::PERM_ACB;
                    end
                end
                else
                begin
                    if (c < b)
                    begin
                        it.low_vertex = c; it.mid_vertex = b; it.high_vertex = a;
                        it.perm_code = tefx_pkg::PERM_CBA;
                    end
                    else if (c < a)
                    begin
                        it.low_vertex = b; it.mid_vertex = c; it.high_vertex = a;
                        it.perm_code = tefx_pkg::PERM_BCA;
                    end
                    else
                    begin
                        it.low_vertex = b; it.mid_vertex = a; it.high_vertex = c;
                        it.perm_code = tefx_pkg::PERM_BAC;
                    end
                end
                add_expected(it);
            end
        endfunction

        function void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
            failures++;
            if (reported < MAX_REPORTS)
            begin
                reported++;
                $display("%0t: %s mismatch: expected 'h%0h, actual 'h%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_item(tefx_pkg::item_t got);
            tefx_pkg::item_t want;
            if (upcoming_items.size() == 0)
            begin
                failures++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("%0t: item with no expectation pending: expected none, actual %p",
                             $time, got);
                end
                return;
            end
            want = upcoming_items.pop_front();
            if (got.kind !== want.kind)
                note_mismatch("kind", 32'(want.kind), 32'(got.kind));
            if (got.low_vertex !== want.low_vertex)
                note_mismatch("low_vertex", 32'(want.low_vertex), 32'(got.low_vertex));
            if (got.mid_vertex !== want.mid_vertex)
                note_mismatch("mid_vertex", 32'(want.mid_vertex), 32'(got.mid_vertex));
            if (got.high_vertex !== want.high_vertex)
                note_mismatch("high_vertex", 32'(want.high_vertex), 32'(got.high_vertex));
            if (got.owner_cell !== want.owner_cell)
                note_mismatch("owner_cell", 32'(want.owner_cell), 32'(got.owner_cell));
            if (got.local_number !== want.local_number)
                note_mismatch("local_number", {28'd0, want.local_number},
                              {28'd0, got.local_number});
            if (got.perm_code !== want.perm_code)
                note_mismatch("perm_code", 32'(want.perm_code), 32'(got.perm_code));
            if (got.degenerate !== want.degenerate)
                note_mismatch("degenerate", 32'(want.degenerate), 32'(got.degenerate));
            if (got.last !== want.last)
                note_mismatch("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tefx_tet_if  tet_ch ();
    tefx_item_if item_ch ();

    tet_edge_face_extractor_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tet   (tet_ch),
        .item  (item_ch)
    );

    edge_face_scoreboard sb = new();
    int unsigned         tets_accepted;
    int unsigned         burst_left;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #500_000;
        $display("FAILURE");
        $finish;
    end

    function automatic tet_in_t tet_of(tefx_pkg::vtx_t a, tefx_pkg::vtx_t b,
                                       tefx_pkg::vtx_t c, tefx_pkg::vtx_t d,
                                       tefx_pkg::vtx_t cell_id);
        tet_in_t t;
        t.v[0] = a;
        t.v[1] = b;
        t.v[2] = c;
        t.v[3] = d;
        t.cell_idx = cell_id;
        return t;
    endfunction

    // Mostly wide random indices, with a share of clustered and extreme
    // values so that equal and nearly equal vertices show up often.
    function automatic tet_in_t random_tet();
        tet_in_t        t;
        tefx_pkg::vtx_t base;
        int             mode;
        mode = $urandom_range(0, 9);
        base = tefx_pkg::vtx_t'($urandom);
        for (int i = 0; i < 4; i++)
        begin
            case (mode)
                5, 6:    t.v[i] = base ^ tefx_pkg::vtx_t'($urandom_range(0, 3));
                7:       t.v[i] = tefx_pkg::vtx_t'($urandom_range(0, 3));
                8:
                begin
                    case ($urandom_range(0, 3))
                        0:       t.v[i] = '0;
                        1:       t.v[i] = tefx_pkg::vtx_t'(1);
                        2:       t.v[i] = VMAX - 1'b1;
                        default: t.v[i] = VMAX;
                    endcase
                end
                default: t.v[i] = tefx_pkg::vtx_t'($urandom);
            endcase
        end
        if (mode == 9)
            t.v[2'($urandom_range(0, 3))] = t.v[2'($urandom_range(0, 3))];
        case ($urandom_range(0, 7))
            0:       t.cell_idx = '0;
            1:       t.cell_idx = VMAX;
            default: t.cell_idx = tefx_pkg::vtx_t'($urandom);
        endcase
        return t;
    endfunction

    // Offers one tetrahedron and returns once it has been accepted. Gaps are
    // only inserted between bursts, so valid stays high inside a burst.
    task automatic offer_tet(input tet_in_t t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                tet_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        tet_ch.valid        <= 1'b1;
        tet_ch.vertex_one   <= t.v[0];
        tet_ch.vertex_two   <= t.v[1];
        tet_ch.vertex_three <= t.v[2];
        tet_ch.vertex_four  <= t.v[3];
        tet_ch.cell_number  <= t.cell_idx;
        do
            @(posedge clk);
        while (tet_ch.ready !== 1'b1);
        sb.note_tet(t);
        tets_accepted++;
    endtask

    initial
    begin
        int waited;
        rst_n               = 1'b0;
        tet_ch.valid        = 1'b0;
        tet_ch.vertex_one   = '0;
        tet_ch.vertex_two   = '0;
        tet_ch.vertex_three = '0;
        tet_ch.vertex_four  = '0;
        tet_ch.cell_number  = '0;
        tets_accepted       = 0;
        burst_left          = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: all equal, extremes, each edge collapsing in turn,
        // and every ordering of the first face.
        offer_tet(tet_of('0, '0, '0, '0, '0));
        offer_tet(tet_of(VMAX, VMAX, VMAX, VMAX, VMAX));
        offer_tet(tet_of(VMAX, '0, VMAX - 1'b1, 1, 31'h5555_5555));
        offer_tet(tet_of(31'h2AAA_AAAA, 31'h5555_5555, 31'h0F0F_0F0F, 31'h70F0_F0F0,
                         31'h2AAA_AAAA));
        offer_tet(tet_of(1, 2, 3, 4, 1));
        offer_tet(tet_of(4, 3, 2, 1, 2));
        offer_tet(tet_of(5, 5, 7, 9, 3));
        offer_tet(tet_of(5, 7, 5, 9, 4));
        offer_tet(tet_of(5, 7, 9, 5, 5));
        offer_tet(tet_of(7, 5, 5, 9, 6));
        offer_tet(tet_of(7, 5, 9, 5, 7));
        offer_tet(tet_of(7, 9, 5, 5, 8));
        offer_tet(tet_of(3, 3, 3, 8, 9));
        offer_tet(tet_of(10, 20, 30, 40, 10));
        offer_tet(tet_of(50, 20, 40, 30, 11));
        offer_tet(tet_of(10, 30, 20, 40, 12));
        offer_tet(tet_of(50, 30, 40, 20, 13));
        offer_tet(tet_of(10, 40, 20, 30, 14));
        offer_tet(tet_of(50, 40, 30, 20, 15));

        for (int n = 0; n < RANDOM_TETS; n++)
            offer_tet(random_tet());
        tet_ch.valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0t: %0d expected items never arrived", $time, sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Item receiver: ready stretches, random stalls and short blackouts,
    // plus one long hold-off once traffic is flowing so the input backs up.
    initial
    begin
        bit held_off;
        int stretch;
        int mode;
        item_ch.ready = 1'b0;
        held_off = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held_off && tets_accepted >= 40)
            begin
                held_off = 1'b1;
                item_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 9);
                stretch = (mode >= 8) ? $urandom_range(1, 8) : $urandom_range(5, 60);
                repeat (stretch)
                begin
                    if (mode <= 3)
                        item_ch.ready <= 1'b1;
                    else if (mode <= 7)
                        item_ch.ready <= ($urandom_range(0, 2) != 0);
                    else
                        item_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        tefx_pkg::item_t seen;
        if (rst_n && item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
        begin
            seen.kind         = item_ch.kind;
            seen.low_vertex   = item_ch.low_vertex;
            seen.mid_vertex   = item_ch.mid_vertex;
            seen.high_vertex  = item_ch.high_vertex;
            seen.owner_cell   = item_ch.owner_cell;
            seen.local_number = item_ch.local_number;
            seen.perm_code    = item_ch.perm_code;
            seen.degenerate   = item_ch.degenerate;
            seen.last         = item_ch.last;
            sb.check_item(seen);
        end
    end

endmodule
